FILE: rtl/tpds_pkg.sv
// shared types, widths and direction codes for the tile direction select
`default_nettype none
package tpds_pkg;

  localparam int SMP_W  = 12;   // Q1.10 sample
  localparam int DIFF_W = 13;   // sample difference
  localparam int MAG_W  = 12;   // magnitude of a difference
  localparam int SQ_W   = 24;   // square of a magnitude
  localparam int ACC_W  = 33;   // energy accumulator

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  typedef enum logic [1:0] {
    DIR_NONE   = 2'd0,
    DIR_LEFT   = 2'd1,
    DIR_UP     = 2'd2,
    DIR_UPLEFT = 2'd3
  } dir_t;

  // one input beat after unpacking
  typedef struct packed {
    logic signed [SMP_W-1:0] cur;
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] up;
    logic signed [SMP_W-1:0] upleft;
    logic                    has_left;
    logic                    has_up;
    logic                    last;
  } in_beat_t;

  // squared terms of one sample
  typedef struct packed {
    logic [SQ_W-1:0] plain;
    logic [SQ_W-1:0] left;
    logic [SQ_W-1:0] up;
    logic [SQ_W-1:0] upleft;
    logic            has_left;
    logic            has_up;
    logic            last;
  } sq_beat_t;

  // tile energies at the last sample
  typedef struct packed {
    logic [ACC_W-1:0] plain;
    logic [ACC_W-1:0] left;
    logic [ACC_W-1:0] up;
    logic [ACC_W-1:0] upleft;
    logic             has_left;
    logic             has_up;
  } sums_t;

endpackage
`default_nettype wire

FILE: rtl/tile_prediction_direction_select.sv
// top level: per-tile prediction direction from sample energies
//
//  channel | dir | tdata                                   | tuser               | tlast
//  in_     | in  | [11:0] cur [23:12] left [35:24] up      | [0] has_left        | last sample
//          |     | [47:36] upleft, signed Q1.10            | [1] has_up          |
//  out_    | out | [1:0] pred_direction, [7:2] zero        | -                   | -
//
// one sample beat per cycle while in_tready is high; input, square, decision and result
// registers in line, so a tile's direction is on out_tdata once its last sample has passed them.
// rst_n clears stage valids and the four accumulators; energies restart
// at zero after every last sample.
// a stalled result only holds back the last sample of a following tile, and the
// samples behind it, once the decision register is also full.
`default_nettype none
module tile_prediction_direction_select
  import tpds_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // cur, left, up, upleft
  input  wire logic [1:0]  in_tuser,   // has_left, has_up
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // pred_direction, zero fill
);

  in_beat_t in_beat;
  sq_beat_t sq_beat;
  sums_t    sums;
  logic     sq_valid;
  logic     sq_go;
  logic     d_free;
  dir_t     out_dir;

  // unpack the input beat
  always_comb begin
    in_beat.cur      = in_tdata[11:0];
    in_beat.left     = in_tdata[23:12];
    in_beat.up       = in_tdata[35:24];
    in_beat.upleft   = in_tdata[47:36];
    in_beat.has_left = in_tuser[0];
    in_beat.has_up   = in_tuser[1];
    in_beat.last     = in_tlast;
  end

  // a last sample waits for room in the decision register
  assign sq_go = sq_valid && (!sq_beat.last || d_free);

  tpds_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_beat  (in_beat),
    .sq_valid (sq_valid),
    .sq_go    (sq_go),
    .sq_beat  (sq_beat)
  );

  tpds_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .sq_go   (sq_go),
    .sq_beat (sq_beat),
    .sums    (sums)
  );

  tpds_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (sq_go && sq_beat.last),
    .sums      (sums),
    .d_free    (d_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_dir   (out_dir)
  );

  assign out_tdata = {6'b0, out_dir};

endmodule
`default_nettype wire

FILE: rtl/tpds_square.sv
// input register and squaring stage
`default_nettype none
module tpds_square
  import tpds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_beat_t in_beat,
  output logic          sq_valid,
  input  wire logic     sq_go,
  output sq_beat_t      sq_beat
);

  logic     s1_valid_r;
  in_beat_t s1_r;
  logic     s2_valid_r;
  sq_beat_t s2_r;
  sq_beat_t sq_nxt;
  logic     s2_free;

  logic signed [DIFF_W-1:0] d_plain, d_left, d_up, d_upleft;
  logic [MAG_W-1:0]         m_plain, m_left, m_up, m_upleft;

  function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] n;
    n = -d;
    return d[DIFF_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  // stage handshake
  assign s2_free  = !s2_valid_r || sq_go;
  assign in_ready = !s1_valid_r || s2_free;

  // sign-extended differences to each neighbor
  always_comb begin
    d_plain  = {s1_r.cur[SMP_W-1], s1_r.cur};
    d_left   = {s1_r.cur[SMP_W-1], s1_r.cur} - {s1_r.left[SMP_W-1], s1_r.left};
    d_up     = {s1_r.cur[SMP_W-1], s1_r.cur} - {s1_r.up[SMP_W-1], s1_r.up};
    d_upleft = {s1_r.cur[SMP_W-1], s1_r.cur} - {s1_r.upleft[SMP_W-1], s1_r.upleft};
    m_plain  = mag(d_plain);
    m_left   = mag(d_left);
    m_up     = mag(d_up);
    m_upleft = mag(d_upleft);
  end

  // four 12x12 squares
  always_comb begin
    sq_nxt.plain    = SQ_W'(m_plain) * SQ_W'(m_plain);
    sq_nxt.left     = SQ_W'(m_left) * SQ_W'(m_left);
    sq_nxt.up       = SQ_W'(m_up) * SQ_W'(m_up);
    sq_nxt.upleft   = SQ_W'(m_upleft) * SQ_W'(m_upleft);
    sq_nxt.has_left = s1_r.has_left;
    sq_nxt.has_up   = s1_r.has_up;
    sq_nxt.last     = s1_r.last;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s2_free)  s2_valid_r <= s1_valid_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_r <= in_beat;
    if (s2_free && s1_valid_r) s2_r <= sq_nxt;
  end

  assign sq_valid = s2_valid_r;
  assign sq_beat  = s2_r;

endmodule
`default_nettype wire

FILE: rtl/tpds_accum.sv
// four saturating energy accumulators, cleared after each tile
`default_nettype none
module tpds_accum
  import tpds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     sq_go,
  input  wire sq_beat_t sq_beat,
  output sums_t         sums
);

  logic [ACC_W-1:0] plain_r, left_r, up_r, upleft_r;
  logic [ACC_W-1:0] plain_nxt, left_nxt, up_nxt, upleft_nxt;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [SQ_W-1:0]  sq);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + (ACC_W+1)'(sq);
    return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
  endfunction

  // running sums including the current beat
  always_comb begin
    plain_nxt  = sat_add(plain_r, sq_beat.plain);
    left_nxt   = sat_add(left_r, sq_beat.left);
    up_nxt     = sat_add(up_r, sq_beat.up);
    upleft_nxt = sat_add(upleft_r, sq_beat.upleft);
  end

  // accumulate, restart from zero after the last sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plain_r  <= '0;
      left_r   <= '0;
      up_r     <= '0;
      upleft_r <= '0;
    end else if (sq_go) begin
      if (sq_beat.last) begin
        plain_r  <= '0;
        left_r   <= '0;
        up_r     <= '0;
        upleft_r <= '0;
      end else begin
        plain_r  <= plain_nxt;
        left_r   <= left_nxt;
        up_r     <= up_nxt;
        upleft_r <= upleft_nxt;
      end
    end
  end

  always_comb begin
    sums.plain    = plain_nxt;
    sums.left     = left_nxt;
    sums.up       = up_nxt;
    sums.upleft   = upleft_nxt;
    sums.has_left = sq_beat.has_left;
    sums.has_up   = sq_beat.has_up;
  end

endmodule
`default_nettype wire

FILE: rtl/tpds_decide.sv
// tile energy register, minimum-energy decision and result register
`default_nettype none
module tpds_decide
  import tpds_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  load,
  input  wire sums_t sums,
  output logic       d_free,
  output logic       out_valid,
  input  wire logic  out_ready,
  output dir_t       out_dir
);

  logic  d_valid_r;
  sums_t d_r;
  logic  out_valid_r;
  dir_t  out_dir_r;
  dir_t  dir_nxt;
  logic  out_free;
  logic  lt01, lt02, lt03, lt10, lt12, lt13, lt20, lt21, lt23;

  assign out_free = !out_valid_r || out_ready;
  assign d_free   = !d_valid_r || out_free;

  // pairwise strict compares
  always_comb begin
    lt01 = d_r.plain < d_r.left;
    lt02 = d_r.plain < d_r.up;
    lt03 = d_r.plain < d_r.upleft;
    lt10 = d_r.left < d_r.plain;
    lt12 = d_r.left < d_r.up;
    lt13 = d_r.left < d_r.upleft;
    lt20 = d_r.up < d_r.plain;
    lt21 = d_r.up < d_r.left;
    lt23 = d_r.up < d_r.upleft;
  end

  // strict-minimum cascade, up-left when no single minimum; with one neighbor a tie goes to it
  always_comb begin
    case ({d_r.has_left, d_r.has_up})
      2'b00:   dir_nxt = DIR_NONE;
      2'b10:   dir_nxt = lt01 ? DIR_NONE : DIR_LEFT;
      2'b01:   dir_nxt = lt02 ? DIR_NONE : DIR_UP;
      2'b11: begin
        if (lt01 && lt02 && lt03)      dir_nxt = DIR_NONE;
        else if (lt10 && lt12 && lt13) dir_nxt = DIR_LEFT;
        else if (lt20 && lt21 && lt23) dir_nxt = DIR_UP;
        else                           dir_nxt = DIR_UPLEFT;
      end
      default: dir_nxt = DIR_NONE;
    endcase
  end

  // valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (d_free)   d_valid_r   <= load;
      if (out_free) out_valid_r <= d_valid_r;
    end
  end

  // payloads
  always_ff @(posedge clk) begin
    if (d_free && load)        d_r       <= sums;
    if (out_free && d_valid_r) out_dir_r <= dir_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_dir   = out_dir_r;

endmodule
`default_nettype wire

FILE: tb/sv/tpds_checker.sv
// checker for the tile direction select: predicts each tile's direction and checks result beats
`default_nettype none
module tpds_checker
  import tpds_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,   // cur, left, up, upleft
  input  wire logic [1:0]  in_tuser,   // has_left, has_up
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,  // pred_direction, zero fill
  output int               mismatch_count,
  output int               dirs_pending
);

  // running tile energies, cleared after every last sample
  logic [ACC_W-1:0] energy_plain;
  logic [ACC_W-1:0] energy_left;
  logic [ACC_W-1:0] energy_up;
  logic [ACC_W-1:0] energy_upleft;

  dir_t expected_dirs[$];

  // add the square of a difference, saturating at the accumulator top
  function automatic logic [ACC_W-1:0] add_square(input logic [ACC_W-1:0] acc,
                                                   input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] mag;
    logic [ACC_W:0]    m;
    logic [ACC_W:0]    sum;
    mag = d[DIFF_W-1] ? -d : d;
    m   = (ACC_W+1)'(mag);
    sum = {1'b0, acc} + m * m;
    return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
  endfunction

  // least-energy direction: strict minimum, else up-left, or the only neighbor on a tie
  function automatic dir_t pick_direction(input logic [ACC_W-1:0] s0, s1, s2, s3,
                                          input logic hl, hu);
    if (!hl && !hu) return DIR_NONE;
    if (!hu) return (s0 < s1) ? DIR_NONE : DIR_LEFT;
    if (!hl) return (s0 < s2) ? DIR_NONE : DIR_UP;
    if (s0 < s1 && s0 < s2 && s0 < s3) return DIR_NONE;
    if (s1 < s0 && s1 < s2 && s1 < s3) return DIR_LEFT;
    if (s2 < s0 && s2 < s1 && s2 < s3) return DIR_UP;
    return DIR_UPLEFT;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    logic signed [SMP_W-1:0]  cur, lft, upv, ulv;
    logic signed [DIFF_W-1:0] d_left, d_up, d_upleft;
    dir_t want;
    if (!rst_n) begin
      energy_plain  = '0;
      energy_left   = '0;
      energy_up     = '0;
      energy_upleft = '0;
    end else begin
      // result beat against the oldest expected direction
      if (out_tvalid && out_tready) begin
        if (expected_dirs.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, tdata %0h",
                                    out_tdata));
        end else begin
          want = expected_dirs.pop_front();
          if (out_tdata[1:0] !== want)
            report_mismatch($sformatf("pred_direction expected %0d got %0d",
                                      want, out_tdata[1:0]));
          if (out_tdata[7:2] !== '0)
            report_mismatch($sformatf("tdata fill expected 0 got %0h", out_tdata[7:2]));
        end
      end
      // sample beat updates the energies
      if (in_tvalid && in_tready) begin
        cur = in_tdata[11:0];
        lft = in_tdata[23:12];
        upv = in_tdata[35:24];
        ulv = in_tdata[47:36];
        d_left   = DIFF_W'(cur) - DIFF_W'(lft);
        d_up     = DIFF_W'(cur) - DIFF_W'(upv);
        d_upleft = DIFF_W'(cur) - DIFF_W'(ulv);
        energy_plain  = add_square(energy_plain, DIFF_W'(cur));
        energy_left   = add_square(energy_left, d_left);
        energy_up     = add_square(energy_up, d_up);
        energy_upleft = add_square(energy_upleft, d_upleft);
        if (in_tlast) begin
          expected_dirs.push_back(pick_direction(energy_plain, energy_left, energy_up,
                                                 energy_upleft, in_tuser[0], in_tuser[1]));
          energy_plain  = '0;
          energy_left   = '0;
          energy_up     = '0;
          energy_upleft = '0;
        end
      end
    end
    dirs_pending = expected_dirs.size();
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb_tile_prediction_direction_select.sv
// testbench top for the tile direction select: clock, reset, sample stimulus and verdict
`default_nettype none
module tb_tile_prediction_direction_select;
  import tpds_pkg::*;

  localparam int ITEM_TARGET  = 1700;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int SAT_TILE_LEN = 600;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // cur, left, up, upleft
  logic [1:0]  in_tuser   = '0;   // has_left, has_up
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // pred_direction, zero fill

  int mismatch_count;
  int dirs_pending;
  int samples_sent = 0;
  int idle_cycles  = 0;
  bit calm_sender  = 1'b0;

  tile_prediction_direction_select dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tpds_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .dirs_pending   (dirs_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_tile_prediction_direction_select failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // idle length: mostly short, a few long
  function automatic int idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(15, 60);
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_smp();
    return SMP_W'($urandom_range(0, 4095));
  endfunction

  // sample near a base value, clipped to the Q1.10 range
  function automatic logic signed [SMP_W-1:0] near(input logic signed [SMP_W-1:0] base,
                                                   input int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return SMP_W'(v);
  endfunction

  // result-side backpressure, with calm stretches of steady ready
  initial begin : ready_pattern
    int hold;
    int calm_left;
    bit calm;
    hold = 0;
    calm_left = 0;
    calm = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(50, 300);
      end
      calm_left--;
      if (hold > 0) begin
        hold--;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else if (out_tready) begin
        if ($urandom_range(0, 3) == 0) begin
          out_tready <= 1'b0;
          hold = idle_len() - 1;
        end
      end else begin
        out_tready <= 1'b1;
        hold = $urandom_range(0, 4);
      end
    end
  end

  // one sample beat, entered and left at a falling edge
  task automatic send_sample(input logic signed [SMP_W-1:0] c, l, u, ul,
                             input logic hl, hu, last);
    int gap;
    gap = (calm_sender || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {ul, u, l, c};
    in_tuser  <= {hu, hl};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    samples_sent++;
  endtask

  // hold the sender until every direction has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (dirs_pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // tile of random length, mostly shaped so one direction wins
  task automatic send_random_tile();
    int len;
    int r;
    int winner;
    bit noisy;
    logic hl, hu, fl, fu;
    logic signed [SMP_W-1:0] c, l, u, ul;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, 8);
    else if (r < 95) len = $urandom_range(9, 64);
    else len = $urandom_range(65, 256);
    hl = 1'($urandom_range(0, 1));
    hu = 1'($urandom_range(0, 1));
    winner = $urandom_range(0, 3);
    noisy = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < len; k++) begin
      if (noisy) begin
        c  = rand_smp();
        l  = rand_smp();
        u  = rand_smp();
        ul = rand_smp();
      end else begin
        c  = (winner == 0) ? near(0, 64) : rand_smp();
        l  = (winner == 1) ? near(c, 24) : rand_smp();
        u  = (winner == 2) ? near(c, 24) : rand_smp();
        ul = (winner == 3) ? near(c, 24) : rand_smp();
      end
      fl = hl;
      fu = hu;
      if ($urandom_range(0, 9) == 0) begin
        fl = 1'($urandom_range(0, 1));
        fu = 1'($urandom_range(0, 1));
      end
      send_sample(c, l, u, ul, fl, fu, k == len - 1);
    end
  endtask

  initial begin : stimulus
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // all-zero single-sample tiles: no neighbor, and ties for each neighbor set
    send_sample(12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, 1'b0, 1'b1);
    send_sample(12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1, 1'b0, 1'b1);
    send_sample(12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, 1'b1, 1'b1);
    send_sample(12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1, 1'b1, 1'b1);
    // left only and up only with plain below the neighbor
    send_sample(12'sd2047, -12'sd2048, -12'sd2048, -12'sd2048, 1'b1, 1'b0, 1'b1);
    send_sample(12'sd0, 12'sd0, 12'sd2047, 12'sd0, 1'b0, 1'b1, 1'b1);
    // both neighbors, each direction winning at the extremes
    send_sample(12'sd0, 12'sd5, -12'sd5, 12'sd2047, 1'b1, 1'b1, 1'b1);
    send_sample(-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 1'b1, 1'b1, 1'b1);
    send_sample(12'sd2047, -12'sd2048, 12'sd2047, 12'sd0, 1'b1, 1'b1, 1'b1);
    send_sample(-12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048, 1'b1, 1'b1, 1'b1);
    // left and up tie below the rest
    send_sample(12'sd1, 12'sd1, 12'sd1, -12'sd2048, 1'b1, 1'b1, 1'b1);
    // flags change inside a tile, the last sample decides
    send_sample(12'sd0, 12'sd100, 12'sd100, 12'sd100, 1'b0, 1'b0, 1'b0);
    send_sample(12'sd0, 12'sd100, 12'sd100, 12'sd100, 1'b1, 1'b1, 1'b1);
    // three-sample tile with alternating extremes
    send_sample(-12'sd2048, 12'sd2047, -12'sd2048, 12'sd2047, 1'b1, 1'b1, 1'b0);
    send_sample(12'sd2047, -12'sd2048, 12'sd2047, -12'sd2048, 1'b1, 1'b1, 1'b0);
    send_sample(-12'sd1, 12'sd1, -12'sd1, 12'sd0, 1'b1, 1'b1, 1'b1);
    wait_for_results();

    // long tile that drives the left and up energies into saturation
    for (int k = 0; k < SAT_TILE_LEN; k++)
      send_sample(12'sd2047, -12'sd2048, -12'sd2048, rand_smp(), 1'b1, 1'b1,
                  k == SAT_TILE_LEN - 1);
    wait_for_results();

    // random tiles, with an occasional full drain
    while (samples_sent < ITEM_TARGET) begin
      calm_sender = ($urandom_range(0, 3) == 0);
      send_random_tile();
      if ($urandom_range(0, 24) == 0) wait_for_results();
    end
    wait_for_results();

    if (mismatch_count == 0) begin
      $display("tb_tile_prediction_direction_select passed");
    end else begin
      $display("tb_tile_prediction_direction_select failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: tile_prediction_direction_select.f
rtl/tpds_pkg.sv
rtl/tpds_square.sv
rtl/tpds_accum.sv
rtl/tpds_decide.sv
rtl/tile_prediction_direction_select.sv
tb/sv/tpds_checker.sv
tb/sv/tb_tile_prediction_direction_select.sv
